// File: hdl/tvss_pkg.sv
// ----------------------------------------------------------------------------
// tvss_pkg
// Shared types, sizes, constants and rate tables of the three-voice synth.
// ----------------------------------------------------------------------------
`default_nettype none

package tvss_pkg;

   localparam int unsigned NUM_REGS = 25;
   localparam int unsigned ADDR_W   = 5;
   localparam int unsigned PH_W     = 28;
   localparam int unsigned FR_W     = 25;
   localparam int unsigned LVL_W    = 24;
   localparam int unsigned PW_W     = 12;
   localparam int unsigned LFSR_W   = 23;
   localparam int unsigned MA_W     = 24;
   localparam int unsigned MB_W     = 25;
   localparam int unsigned MP_W     = MA_W + MB_W;
   localparam int unsigned MIX_W    = 17;
   localparam int unsigned ST_W     = 48;
   localparam int unsigned WIDE_W   = 52;
   localparam int unsigned QR_W     = 50;
   localparam int unsigned DIVR_W   = 27;
   localparam int unsigned LD_VOICE = 10;
   localparam int unsigned LD_FILT  = 4;

   localparam int unsigned REG_CUT_LO = 21;
   localparam int unsigned REG_RES    = 23;

   localparam logic [LVL_W-1:0]  LVL_MAX   = 24'hffffff;
   localparam logic [LVL_W-1:0]  SUS_STEP  = 24'h111111;
   localparam logic [LFSR_W-1:0] LFSR_SEED = 23'h7ffff8;
   localparam logic [8:0]        FREQ_MUL  = 9'd359;

   typedef enum logic [1:0] {
      ENV_REL,
      ENV_ATK,
      ENV_DEC,
      ENV_SUS
   } env_type;

   typedef enum logic {
      CMD_WRITE,
      CMD_SAMPLE
   } cmd_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_LOAD,
      ST_PHASE,
      ST_DIV1,
      ST_DIV2,
      ST_ENV,
      ST_WAVE,
      ST_VMUL,
      ST_VACC,
      ST_FLOAD,
      ST_QLO,
      ST_QHI,
      ST_QSUM,
      ST_FCOMB,
      ST_FMIX,
      ST_OUT
   } state_type;

   function automatic logic [17:0] atk_rate(input logic [3:0] k);
      logic [17:0] r;
      case (k)
         4'd0:    r = 18'd168867;
         4'd1:    r = 18'd47495;
         4'd2:    r = 18'd24124;
         4'd3:    r = 18'd15998;
         4'd4:    r = 18'd10200;
         4'd5:    r = 18'd6908;
         4'd6:    r = 18'd5692;
         4'd7:    r = 18'd4855;
         4'd8:    r = 18'd3877;
         4'd9:    r = 18'd1555;
         4'd10:   r = 18'd777;
         4'd11:   r = 18'd486;
         4'd12:   r = 18'd389;
         4'd13:   r = 18'd129;
         4'd14:   r = 18'd77;
         default: r = 18'd48;
      endcase
      return r;
   endfunction

   function automatic logic [15:0] rel_rate(input logic [3:0] k);
      logic [15:0] r;
      case (k)
         4'd0:    r = 16'd42660;
         4'd1:    r = 16'd15468;
         4'd2:    r = 16'd7857;
         4'd3:    r = 16'd5210;
         4'd4:    r = 16'd3322;
         4'd5:    r = 16'd2250;
         4'd6:    r = 16'd1853;
         4'd7:    r = 16'd1581;
         4'd8:    r = 16'd1262;
         4'd9:    r = 16'd506;
         4'd10:   r = 16'd253;
         4'd11:   r = 16'd158;
         4'd12:   r = 16'd126;
         4'd13:   r = 16'd42;
         4'd14:   r = 16'd25;
         default: r = 16'd15;
      endcase
      return r;
   endfunction

   function automatic logic signed [ST_W-1:0] sat48(input logic signed [WIDE_W-1:0] x);
      logic signed [WIDE_W-1:0] hi;
      logic signed [WIDE_W-1:0] lo;
      hi = {{(WIDE_W-ST_W+1){1'b0}}, {(ST_W-1){1'b1}}};
      lo = {{(WIDE_W-ST_W+1){1'b1}}, {(ST_W-1){1'b0}}};
      if (x > hi) return hi[ST_W-1:0];
      if (x < lo) return lo[ST_W-1:0];
      return x[ST_W-1:0];
   endfunction

endpackage

`default_nettype wire

// File: hdl/three_voice_sound_synth.sv
// ----------------------------------------------------------------------------
// three_voice_sound_synth
// Three-voice subtractive synthesizer with envelopes and state-variable filter.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: tuser = 0 writes chip register tdata[4:0] with tdata[12:5]
//   (addresses 25..31 are dropped); tuser = 1 asks for one audio sample.
//   rsp channel: one transaction per sample request, tdata = signed sample.
//   A register write leaves the sequencer idle. A sample request walks the
//   voices in order on one multiplier and one compare/subtract unit; a voice
//   whose hard sync fires also runs the bit-serial sync divider, states
//   DIV1 and DIV2 per quotient bit over 25 bits.
//   Chip registers sit in a small memory read one byte per cycle; the
//   register fetch per voice reads ten bytes.
//   req_tready is high only while the sequencer is idle.
//   The result sits in an output register; a new request is taken while it
//   waits. If the receiver still stalls when the next sample is done, the
//   sequencer holds in its final step until rsp_tready.
//   Reset (synchronous, active high) clears registers, voice and filter state.
// ----------------------------------------------------------------------------
`default_nettype none

module three_voice_sound_synth #(
   parameter int unsigned VOICES           = 3,
   parameter int unsigned FILTER_FRAC_BITS = 16
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [15:0] req_tdata,   // [4:0] reg_addr, [12:5] reg_data
   input  wire logic        req_tuser,   // [0] cmd
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [15:0] rsp_tdata    // [15:0] sample
);

   localparam int unsigned VW = (VOICES > 1) ? $clog2(VOICES) : 1;
   localparam int unsigned FB = FILTER_FRAC_BITS;

   localparam int unsigned AW  = tvss_pkg::ADDR_W;
   localparam int unsigned PHW = tvss_pkg::PH_W;
   localparam int unsigned FRW = tvss_pkg::FR_W;
   localparam int unsigned LW  = tvss_pkg::LVL_W;
   localparam int unsigned MXW = tvss_pkg::MIX_W;
   localparam int unsigned SW  = tvss_pkg::ST_W;
   localparam int unsigned WW  = tvss_pkg::WIDE_W;
   localparam int unsigned QW  = tvss_pkg::QR_W;
   localparam int unsigned RW  = tvss_pkg::DIVR_W;

   function automatic logic signed [WW-1:0] qtrunc(input logic signed [WW-1:0] t);
      logic [WW-1:0] m;
      m = t[WW-1] ? WW'(-t) : WW'(t);
      m = m >> FB;
      return t[WW-1] ? -$signed(m) : $signed(m);
   endfunction

   // resonance table
   logic [tvss_pkg::MB_W-1:0] q_tab [16];
   for (genvar k = 0; k < 16; k++) begin : g_qtab
      localparam longint unsigned QV =
         ((64'(120 - 4 * k) << FILTER_FRAC_BITS) + 64'd50) / 64'd100;
      assign q_tab[k] = tvss_pkg::MB_W'(QV);
   end

   tvss_pkg::state_type state_ff, state_in;

   // register memory
   logic [7:0]    reg_mem [tvss_pkg::NUM_REGS];
   logic          reg_vld_ff [tvss_pkg::NUM_REGS];
   logic [AW-1:0] rd_addr;
   logic [7:0]    rd_data_ff;
   logic          req_acc, wr_en;

   // voice state
   logic [PHW-1:0]              phase_ff [VOICES];
   logic [LW-1:0]               lvl_ff   [VOICES];
   tvss_pkg::env_type           eph_ff   [VOICES];
   logic [tvss_pkg::PW_W-1:0]   pw_ff    [VOICES];
   logic [4:0]                  tap_ff   [VOICES];
   logic [tvss_pkg::LFSR_W-1:0] lfsr_ff  [VOICES];
   logic [7:0]                  nbyte_ff [VOICES];

   // sequencer and work registers
   logic [VW-1:0]  vidx_ff;
   logic [3:0]     ld_cnt_ff;
   logic [1:0]     fstep_ff;
   logic [7:0]     wb_ff [tvss_pkg::LD_VOICE];
   logic [FRW-1:0] fr_ff, pfr_ff;
   logic [PHW-1:0] ph_ff, src_ff;
   logic [FRW-1:0] div_a_ff, div_q_ff;
   logic [RW-1:0]  div_r_ff;
   logic [4:0]     div_i_ff;
   logic signed [MXW-1:0] mix0_ff, mix1_ff;
   logic [7:0]     mag_ff;
   logic           neg_ff;
   logic [tvss_pkg::MP_W-1:0] mul_ff;
   logic [QW-1:0]  qr_ff;
   logic signed [SW-1:0] high_ff, band_ff, low_ff;
   logic signed [WW-1:0] acc_ff;
   logic [15:0]    out_ff;
   logic           out_vld_ff;

   // decode
   logic [VW-1:0]  pidx;
   logic [AW-1:0]  vbase, pbase;
   logic [7:0]     flags;
   logic [FRW-1:0] fr_new, pfr_new;
   logic [PHW-1:0] ph_new, sync_src, ring_src;
   logic           sync_hit;
   logic [RW-1:0]  div_t;
   logic           load_done;

   // shared multiplier
   logic [tvss_pkg::MA_W-1:0] mul_a;
   logic [tvss_pkg::MB_W-1:0] mul_b;
   logic signed [SW-1:0]      qx;
   logic [SW-1:0]             qx_mag;
   logic [tvss_pkg::MB_W-1:0] qb, fc;
   logic [2:0]                fmode;

   // envelope / wave
   tvss_pkg::env_type env_n;
   logic [LW-1:0]   lvl_n, sus;
   logic signed [LW+1:0] lvl_s, lvl_t;
   logic            pw_load;
   logic [4:0]      tap_n;
   logic [tvss_pkg::LFSR_W-1:0] lfsr_n;
   logic [7:0]      tri_w, saw_w, pul_w, wave;

   // mix and filter arithmetic
   logic signed [32:0]   vprod;
   logic signed [MXW-1:0] vscaled;
   logic signed [WW-1:0] qm, fsum, fx, ft, smp;

   assign req_acc    = req_tvalid && req_tready;
   assign wr_en      = req_acc && (req_tuser == tvss_pkg::CMD_WRITE) &&
                       (req_tdata[4:0] < AW'(tvss_pkg::NUM_REGS));
   assign req_tready = (state_ff == tvss_pkg::ST_IDLE);
   assign rsp_tvalid = out_vld_ff;
   assign rsp_tdata  = out_ff;

   assign pidx  = (vidx_ff == '0) ? VW'(VOICES - 1) : vidx_ff - 1'b1;
   assign vbase = AW'(vidx_ff) * AW'(7);
   assign pbase = AW'(pidx) * AW'(7);
   assign flags = wb_ff[4];

   assign load_done = (state_ff == tvss_pkg::ST_FLOAD) ?
                      (ld_cnt_ff == 4'(tvss_pkg::LD_FILT)) :
                      (ld_cnt_ff == 4'(tvss_pkg::LD_VOICE));

   always_comb begin
      rd_addr = '0;
      if (state_ff == tvss_pkg::ST_FLOAD) begin
         rd_addr = AW'(tvss_pkg::REG_CUT_LO) + AW'(ld_cnt_ff[1:0]);
      end else if (ld_cnt_ff < 4'd7) begin
         rd_addr = vbase + AW'(ld_cnt_ff);
      end else if (ld_cnt_ff == 4'd7) begin
         rd_addr = pbase;
      end else if (ld_cnt_ff == 4'd8) begin
         rd_addr = pbase + AW'(1);
      end else begin
         rd_addr = AW'(tvss_pkg::REG_RES);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         reg_mem[req_tdata[4:0]] <= req_tdata[12:5];
      end
      rd_data_ff <= reg_vld_ff[rd_addr] ? reg_mem[rd_addr] : 8'd0;
   end

   // phase and sync
   assign fr_new   = FRW'({wb_ff[1], wb_ff[0]}) * FRW'(tvss_pkg::FREQ_MUL);
   assign pfr_new  = FRW'({wb_ff[8], wb_ff[7]}) * FRW'(tvss_pkg::FREQ_MUL);
   assign ph_new   = phase_ff[vidx_ff] + PHW'(fr_new);
   assign sync_src = (VOICES == 1) ? ph_new : src_ff;
   assign ring_src = (VOICES == 1) ? ph_ff : src_ff;
   assign sync_hit = flags[1] && (sync_src < PHW'(pfr_new));
   assign div_t    = {div_r_ff[RW-2:0], 1'b0} +
                     (fr_ff[div_i_ff] ? RW'(div_a_ff) : RW'(0));

   // envelope
   assign sus   = LW'(wb_ff[6][7:4]) * tvss_pkg::SUS_STEP;
   assign lvl_s = $signed({2'b00, lvl_ff[vidx_ff]});

   always_comb begin
      if (!flags[0]) begin
         env_n = tvss_pkg::ENV_REL;
      end else if (eph_ff[vidx_ff] == tvss_pkg::ENV_REL) begin
         env_n = tvss_pkg::ENV_ATK;
      end else begin
         env_n = eph_ff[vidx_ff];
      end
      lvl_n = lvl_ff[vidx_ff];
      lvl_t = lvl_s;
      case (env_n)
         tvss_pkg::ENV_ATK: begin
            lvl_t = lvl_s + $signed({8'd0, tvss_pkg::atk_rate(wb_ff[5][7:4])});
            if (lvl_t >= $signed({2'b00, tvss_pkg::LVL_MAX})) begin
               lvl_n = tvss_pkg::LVL_MAX;
               env_n = tvss_pkg::ENV_DEC;
            end else begin
               lvl_n = lvl_t[LW-1:0];
            end
         end
         tvss_pkg::ENV_DEC: begin
            lvl_t = lvl_s - $signed({10'd0, tvss_pkg::rel_rate(wb_ff[5][3:0])});
            if (lvl_t <= $signed({2'b00, sus})) begin
               lvl_n = sus;
               env_n = tvss_pkg::ENV_SUS;
            end else begin
               lvl_n = lvl_t[LW-1:0];
            end
         end
         tvss_pkg::ENV_SUS: begin
            if (lvl_ff[vidx_ff] != sus) begin
               env_n = tvss_pkg::ENV_ATK;
            end
         end
         default: begin
            lvl_t = lvl_s - $signed({10'd0, tvss_pkg::rel_rate(wb_ff[6][3:0])});
            lvl_n = lvl_t[LW+1] ? '0 : lvl_t[LW-1:0];
         end
      endcase
   end

   // pulse latch and noise
   assign pw_load = (ph_ff < PHW'(fr_ff));
   assign tap_n   = ph_ff[27:23];
   assign lfsr_n  = {lfsr_ff[vidx_ff][21:0],
                     lfsr_ff[vidx_ff][22] ^ lfsr_ff[vidx_ff][17]};

   // waveform
   always_comb begin
      tri_w = ph_ff[27] ? ~ph_ff[26:19] : ph_ff[26:19];
      if (flags[2] && !ring_src[27]) begin
         tri_w = ~tri_w;
      end
      saw_w = ph_ff[27:20];
      pul_w = (ph_ff > {pw_ff[vidx_ff], 16'd0}) ? 8'd0 : 8'hff;
      wave  = 8'hff;
      if (flags[4]) wave = wave & tri_w;
      if (flags[5]) wave = wave & saw_w;
      if (flags[6]) wave = wave & pul_w;
      if (flags[7]) wave = wave & nbyte_ff[vidx_ff];
   end

   // voice scaling, floor by 2^18
   assign vprod   = neg_ff ? -$signed({1'b0, mul_ff[31:0]}) : $signed({1'b0, mul_ff[31:0]});
   assign vscaled = MXW'(vprod >>> 18);

   // filter operands
   assign fc     = tvss_pkg::MB_W'({wb_ff[1], wb_ff[0][2:0]}) << (FB - 11);
   assign fmode  = wb_ff[3][6:4];
   assign qx     = (fstep_ff == 2'd1) ? high_ff : band_ff;
   assign qb     = (fstep_ff == 2'd0) ? q_tab[wb_ff[2][7:4]] : fc;
   assign qx_mag = qx[SW-1] ? SW'(-qx) : SW'(qx);
   assign qm     = qx[SW-1] ? -$signed(WW'(qr_ff)) : $signed(WW'(qr_ff));

   always_comb begin
      case (fstep_ff)
         2'd0:    fsum = (WW'(mix1_ff) <<< FB) - qm - WW'(low_ff);
         2'd1:    fsum = WW'(band_ff) + qm;
         default: fsum = WW'(low_ff) + qm;
      endcase
      case (fstep_ff)
         2'd0:    fx = WW'(low_ff);
         2'd1:    fx = WW'(band_ff);
         default: fx = WW'(high_ff);
      endcase
      ft  = qtrunc((acc_ff <<< FB) + fx);
      smp = WW'(mix0_ff) + acc_ff;
   end

   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         tvss_pkg::ST_VMUL: begin
            mul_a = tvss_pkg::MA_W'(mag_ff);
            mul_b = tvss_pkg::MB_W'(lvl_ff[vidx_ff]);
         end
         tvss_pkg::ST_QLO: begin
            mul_a = qx_mag[23:0];
            mul_b = qb;
         end
         tvss_pkg::ST_QHI: begin
            mul_a = qx_mag[47:24];
            mul_b = qb;
         end
         default: begin
            mul_a = '0;
         end
      endcase
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         tvss_pkg::ST_IDLE: begin
            if (req_acc && req_tuser == tvss_pkg::CMD_SAMPLE) state_in = tvss_pkg::ST_LOAD;
         end
         tvss_pkg::ST_LOAD: begin
            if (load_done) state_in = tvss_pkg::ST_PHASE;
         end
         tvss_pkg::ST_PHASE: begin
            state_in = sync_hit ? tvss_pkg::ST_DIV1 : tvss_pkg::ST_ENV;
         end
         tvss_pkg::ST_DIV1: state_in = tvss_pkg::ST_DIV2;
         tvss_pkg::ST_DIV2: begin
            state_in = (div_i_ff == 5'd0) ? tvss_pkg::ST_ENV : tvss_pkg::ST_DIV1;
         end
         tvss_pkg::ST_ENV:  state_in = tvss_pkg::ST_WAVE;
         tvss_pkg::ST_WAVE: state_in = tvss_pkg::ST_VMUL;
         tvss_pkg::ST_VMUL: state_in = tvss_pkg::ST_VACC;
         tvss_pkg::ST_VACC: begin
            state_in = (vidx_ff == VW'(VOICES - 1)) ? tvss_pkg::ST_FLOAD : tvss_pkg::ST_LOAD;
         end
         tvss_pkg::ST_FLOAD: begin
            if (load_done) state_in = tvss_pkg::ST_QLO;
         end
         tvss_pkg::ST_QLO:  state_in = tvss_pkg::ST_QHI;
         tvss_pkg::ST_QHI:  state_in = tvss_pkg::ST_QSUM;
         tvss_pkg::ST_QSUM: state_in = tvss_pkg::ST_FCOMB;
         tvss_pkg::ST_FCOMB: begin
            state_in = (fstep_ff == 2'd2) ? tvss_pkg::ST_FMIX : tvss_pkg::ST_QLO;
         end
         tvss_pkg::ST_FMIX: begin
            if (fstep_ff == 2'd2) state_in = tvss_pkg::ST_OUT;
         end
         tvss_pkg::ST_OUT: begin
            if (!out_vld_ff || rsp_tready) state_in = tvss_pkg::ST_IDLE;
         end
         default: state_in = tvss_pkg::ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= tvss_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // control and persistent state
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < tvss_pkg::NUM_REGS; i++) reg_vld_ff[i] <= 1'b0;
         for (int v = 0; v < VOICES; v++) begin
            phase_ff[v] <= '0;
            lvl_ff[v]   <= '0;
            eph_ff[v]   <= tvss_pkg::ENV_REL;
            pw_ff[v]    <= '0;
            tap_ff[v]   <= '0;
            lfsr_ff[v]  <= tvss_pkg::LFSR_SEED;
            nbyte_ff[v] <= '0;
         end
         band_ff    <= '0;
         low_ff     <= '0;
         vidx_ff    <= '0;
         ld_cnt_ff  <= '0;
         fstep_ff   <= '0;
         out_vld_ff <= 1'b0;
      end else begin
         if (wr_en) reg_vld_ff[req_tdata[4:0]] <= 1'b1;
         if (state_ff == tvss_pkg::ST_OUT && (!out_vld_ff || rsp_tready)) begin
            out_vld_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_vld_ff <= 1'b0;
         end
         case (state_ff)
            tvss_pkg::ST_IDLE: begin
               vidx_ff   <= '0;
               ld_cnt_ff <= '0;
            end
            tvss_pkg::ST_LOAD, tvss_pkg::ST_FLOAD: begin
               ld_cnt_ff <= load_done ? 4'd0 : ld_cnt_ff + 4'd1;
               fstep_ff  <= '0;
            end
            tvss_pkg::ST_ENV: begin
               phase_ff[vidx_ff] <= ph_ff;
               lvl_ff[vidx_ff]   <= lvl_n;
               eph_ff[vidx_ff]   <= env_n;
               if (pw_load) pw_ff[vidx_ff] <= {wb_ff[3][3:0], wb_ff[2]};
               if (tap_n != tap_ff[vidx_ff]) begin
                  tap_ff[vidx_ff]   <= tap_n;
                  lfsr_ff[vidx_ff]  <= lfsr_n;
                  nbyte_ff[vidx_ff] <= {lfsr_n[22], lfsr_n[20], lfsr_n[16], lfsr_n[13],
                                        lfsr_n[11], lfsr_n[7], lfsr_n[4], lfsr_n[2]};
               end
            end
            tvss_pkg::ST_VACC: begin
               if (vidx_ff != VW'(VOICES - 1)) vidx_ff <= vidx_ff + 1'b1;
            end
            tvss_pkg::ST_FCOMB: begin
               case (fstep_ff)
                  2'd1:    band_ff <= tvss_pkg::sat48(fsum);
                  2'd2:    low_ff  <= tvss_pkg::sat48(fsum);
                  default: band_ff <= band_ff;
               endcase
               fstep_ff <= (fstep_ff == 2'd2) ? 2'd0 : fstep_ff + 2'd1;
            end
            tvss_pkg::ST_FMIX: begin
               fstep_ff <= (fstep_ff == 2'd2) ? 2'd0 : fstep_ff + 2'd1;
            end
            default: begin
               vidx_ff <= vidx_ff;
            end
         endcase
      end
   end

   // datapath
   always_ff @(posedge clock) begin
      mul_ff <= mul_a * mul_b;
      if ((state_ff == tvss_pkg::ST_LOAD || state_ff == tvss_pkg::ST_FLOAD) &&
          ld_cnt_ff != 4'd0) begin
         wb_ff[ld_cnt_ff - 4'd1] <= rd_data_ff;
      end
      case (state_ff)
         tvss_pkg::ST_IDLE: begin
            mix0_ff <= '0;
            mix1_ff <= '0;
            src_ff  <= phase_ff[VOICES-1];
         end
         tvss_pkg::ST_PHASE: begin
            fr_ff    <= fr_new;
            pfr_ff   <= pfr_new;
            ph_ff    <= ph_new;
            div_a_ff <= sync_src[FRW-1:0];
            div_r_ff <= '0;
            div_q_ff <= '0;
            div_i_ff <= 5'(FRW - 1);
         end
         tvss_pkg::ST_DIV1: begin
            if (div_t >= RW'(pfr_ff)) begin
               div_r_ff <= div_t - RW'(pfr_ff);
               div_q_ff <= {div_q_ff[FRW-2:0], 1'b1};
            end else begin
               div_r_ff <= div_t;
               div_q_ff <= {div_q_ff[FRW-2:0], 1'b0};
            end
         end
         tvss_pkg::ST_DIV2: begin
            if (div_r_ff >= RW'(pfr_ff)) begin
               div_r_ff <= div_r_ff - RW'(pfr_ff);
               if (div_i_ff == 5'd0) ph_ff <= PHW'(div_q_ff + 1'b1);
               else div_q_ff <= div_q_ff + 1'b1;
            end else if (div_i_ff == 5'd0) begin
               ph_ff <= PHW'(div_q_ff);
            end
            div_i_ff <= div_i_ff - 5'd1;
         end
         tvss_pkg::ST_WAVE: begin
            neg_ff <= !wave[7];
            mag_ff <= wave[7] ? wave - 8'd128 : 8'd128 - wave;
         end
         tvss_pkg::ST_VACC: begin
            if (wb_ff[9][3'(vidx_ff)]) mix1_ff <= mix1_ff + vscaled;
            else mix0_ff <= mix0_ff + vscaled;
            src_ff <= ph_ff;
         end
         tvss_pkg::ST_QHI: begin
            qr_ff <= QW'(mul_ff >> FB);
         end
         tvss_pkg::ST_QSUM: begin
            qr_ff <= qr_ff + (QW'(mul_ff) << (24 - FB));
         end
         tvss_pkg::ST_FCOMB: begin
            if (fstep_ff == 2'd0) high_ff <= tvss_pkg::sat48(fsum);
            acc_ff <= '0;
         end
         tvss_pkg::ST_FMIX: begin
            if (fmode[fstep_ff]) acc_ff <= ft;
         end
         tvss_pkg::ST_OUT: begin
            if (!out_vld_ff || rsp_tready) begin
               if (smp > WW'(32767)) out_ff <= 16'h7fff;
               else if (smp < -WW'(32768)) out_ff <= 16'h8000;
               else out_ff <= smp[15:0];
            end
         end
         default: begin
            neg_ff <= neg_ff;
         end
      endcase
   end

   a_div_rem: assert property (@(posedge clock) disable iff (reset)
      (state_ff == tvss_pkg::ST_DIV1) |-> (div_r_ff < RW'(pfr_ff)))
      else $error("sync divider remainder out of range");

   a_busy: assert property (@(posedge clock) disable iff (reset)
      (req_acc && req_tuser == tvss_pkg::CMD_SAMPLE) |=> !req_tready)
      else $error("request taken during sample computation");

   a_out_src: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> ($past(state_ff) == tvss_pkg::ST_OUT))
      else $error("result raised outside output step");

   a_vidx: assert property (@(posedge clock) disable iff (reset)
      (state_ff != tvss_pkg::ST_IDLE) |-> (vidx_ff <= VW'(VOICES - 1)))
      else $error("voice index out of range");

endmodule

`default_nettype wire

// File: bench/three_voice_sound_synth_test.sv
// ----------------------------------------------------------------------------
// three_voice_sound_synth_test
// Self-checking bench for the three-voice synth: register writes and sample
// requests are streamed in with bursty timing, each sample is predicted by an
// in-bench model of voices, envelopes and filter and checked as it leaves.
// ----------------------------------------------------------------------------
`default_nettype none

module three_voice_sound_synth_test;

   localparam int unsigned FRAC      = 16;
   localparam int          MAX_CYCLE = 4000000;
   localparam int          ITEM_GOAL = 1850;
   localparam longint      S48_HI    = 64'sh00007fffffffffff;
   localparam longint      S48_LO    = -S48_HI - 1;

   localparam int ATK_RATE [16] = '{168867, 47495, 24124, 15998, 10200, 6908, 5692, 4855,
                                    3877, 1555, 777, 486, 389, 129, 77, 48};
   localparam int REL_RATE [16] = '{42660, 15468, 7857, 5210, 3322, 2250, 1853, 1581,
                                    1262, 506, 253, 158, 126, 42, 25, 15};

   logic        clock = 1'b0;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [15:0] req_tdata;   // [4:0] reg_addr, [12:5] reg_data
   logic        req_tuser;   // [0] cmd
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [15:0] rsp_tdata;   // [15:0] sample

   three_voice_sound_synth dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // synth state as seen by the bench
   logic [7:0]        chip_regs [tvss_pkg::NUM_REGS];
   logic [27:0]       osc_phase [3];
   int                env_level [3];
   tvss_pkg::env_type env_state [3];
   logic [11:0]       pw_latch  [3];
   logic [4:0]        noise_tap [3];
   logic [22:0]       noise_sr  [3];
   logic [7:0]        noise_out [3];
   longint            svf_band;
   longint            svf_low;

   logic [15:0] expected_samples [$];
   int          errors;
   int          cycles;
   int          items_sent;
   int          writes_sent;
   int          samples_checked;
   int          burst_left;

   function automatic longint unsigned osc_freq(int v);
      return longint'({chip_regs[7*v+1], chip_regs[7*v]}) * 359;
   endfunction

   function automatic longint clip48(longint x);
      if (x > S48_HI) return S48_HI;
      if (x < S48_LO) return S48_LO;
      return x;
   endfunction

   // trunc(a * b / 2^FRAC) without overflowing 64 bits
   function automatic longint fix_mul(longint a, longint unsigned b);
      longint unsigned ua;
      longint unsigned r;
      ua = (a < 0) ? longint'(-a) : longint'(a);
      r  = (((ua >> 24) * b) << (24 - FRAC)) + (((ua & 64'hffffff) * b) >> FRAC);
      return (a < 0) ? -longint'(r) : longint'(r);
   endfunction

   function automatic longint fix_trunc(longint x);
      if (x >= 0) return x >>> FRAC;
      return -((-x) >>> FRAC);
   endfunction

   task automatic clear_synth_state();
      for (int i = 0; i < tvss_pkg::NUM_REGS; i++) chip_regs[i] = 8'h00;
      for (int v = 0; v < 3; v++) begin
         osc_phase[v] = '0;
         env_level[v] = 0;
         env_state[v] = tvss_pkg::ENV_REL;
         pw_latch[v]  = '0;
         noise_tap[v] = '0;
         noise_sr[v]  = 23'h7ffff8;
         noise_out[v] = '0;
      end
      svf_band = 0;
      svf_low  = 0;
   endtask

   task automatic compute_sample();
      longint          mix [2];
      int              p;
      longint unsigned fr, pfr, fc, q;
      logic [7:0]      flags, tri_v, saw, pul, w;
      int              sus;
      longint          prod, high, acc, s;
      logic [2:0]      mode;
      mix[0] = 0;
      mix[1] = 0;
      for (int c = 0; c < 3; c++) begin
         p     = (c == 0) ? 2 : c - 1;
         fr    = osc_freq(c);
         pfr   = osc_freq(p);
         flags = chip_regs[7*c+4];
         sus   = int'(chip_regs[7*c+6][7:4]) * 32'h111111;

         osc_phase[c] = 28'(osc_phase[c] + fr);
         if (osc_phase[p] < pfr && flags[1])
            osc_phase[c] = 28'((longint'(osc_phase[p]) * fr) / pfr);

         if (flags[0]) begin
            if (env_state[c] == tvss_pkg::ENV_REL) env_state[c] = tvss_pkg::ENV_ATK;
         end else begin
            env_state[c] = tvss_pkg::ENV_REL;
         end
         case (env_state[c])
            tvss_pkg::ENV_ATK: begin
               env_level[c] += ATK_RATE[chip_regs[7*c+5][7:4]];
               if (env_level[c] >= 'hffffff) begin
                  env_level[c] = 'hffffff;
                  env_state[c] = tvss_pkg::ENV_DEC;
               end
            end
            tvss_pkg::ENV_DEC: begin
               env_level[c] -= REL_RATE[chip_regs[7*c+5][3:0]];
               if (env_level[c] <= sus) begin
                  env_level[c] = sus;
                  env_state[c] = tvss_pkg::ENV_SUS;
               end
            end
            tvss_pkg::ENV_SUS: begin
               if (env_level[c] != sus) env_state[c] = tvss_pkg::ENV_ATK;
            end
            default: begin
               env_level[c] -= REL_RATE[chip_regs[7*c+6][3:0]];
               if (env_level[c] < 0) env_level[c] = 0;
            end
         endcase

         if (osc_phase[c] < fr) pw_latch[c] = {chip_regs[7*c+3][3:0], chip_regs[7*c+2]};

         tri_v = osc_phase[c][27] ? ~osc_phase[c][26:19] : osc_phase[c][26:19];
         saw   = osc_phase[c][27:20];
         pul   = (osc_phase[c] > {pw_latch[c], 16'h0000}) ? 8'h00 : 8'hff;
         if (noise_tap[c] != osc_phase[c][27:23]) begin
            noise_tap[c] = osc_phase[c][27:23];
            noise_sr[c]  = {noise_sr[c][21:0], noise_sr[c][22] ^ noise_sr[c][17]};
            noise_out[c] = {noise_sr[c][22], noise_sr[c][20], noise_sr[c][16], noise_sr[c][13],
                            noise_sr[c][11], noise_sr[c][7], noise_sr[c][4], noise_sr[c][2]};
         end
         if (flags[2] && !osc_phase[p][27]) tri_v = ~tri_v;

         w = 8'hff;
         if (flags[4]) w &= tri_v;
         if (flags[5]) w &= saw;
         if (flags[6]) w &= pul;
         if (flags[7]) w &= noise_out[c];

         prod = (longint'(w) - 128) * longint'(env_level[c]);
         mix[chip_regs[tvss_pkg::REG_RES][c]] += prod >>> 18;
      end

      fc   = longint'({chip_regs[22], chip_regs[tvss_pkg::REG_CUT_LO][2:0]}) << (FRAC - 11);
      q    = (((longint'(120) - 4 * chip_regs[tvss_pkg::REG_RES][7:4]) << FRAC) + 50) / 100;
      mode = chip_regs[24][6:4];
      acc  = 0;
      high     = clip48(mix[1] * (64'sd1 << FRAC) - fix_mul(svf_band, q) - svf_low);
      svf_band = clip48(svf_band + fix_mul(high, fc));
      svf_low  = clip48(svf_low + fix_mul(svf_band, fc));
      if (mode[0]) acc = fix_trunc(acc * (64'sd1 << FRAC) + svf_low);
      if (mode[1]) acc = fix_trunc(acc * (64'sd1 << FRAC) + svf_band);
      if (mode[2]) acc = fix_trunc(acc * (64'sd1 << FRAC) + high);
      s = mix[0] + acc;
      if (s > 32767) s = 32767;
      if (s < -32768) s = -32768;
      expected_samples.push_back(s[15:0]);
   endtask

   // one transaction on the request side, then maybe a gap between bursts
   task automatic send_item(tvss_pkg::cmd_type cmd, logic [4:0] addr, logic [7:0] data);
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= {3'b000, data, addr};
      do @(posedge clock); while (!req_tready);
      if (cmd == tvss_pkg::CMD_SAMPLE) begin
         compute_sample();
         items_sent++;
      end else if (addr < tvss_pkg::NUM_REGS) begin
         chip_regs[addr] = data;
         items_sent++;
         writes_sent++;
      end
      if (burst_left == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 20)) @(posedge clock);
         burst_left = ($urandom_range(0, 3) == 0) ? 200 : $urandom_range(1, 30);
      end else begin
         burst_left--;
      end
   endtask

   task automatic write_reg(int addr, int data);
      send_item(tvss_pkg::CMD_WRITE, 5'(addr), 8'(data));
   endtask

   task automatic take_sample();
      send_item(tvss_pkg::CMD_SAMPLE, 5'($urandom), 8'($urandom));
   endtask

   task automatic test_corner_cases();
      write_reg(0, 8'hff);
      write_reg(1, 8'hff);
      write_reg(2, 8'h00);
      write_reg(3, 8'hff);
      write_reg(5, 8'h00);
      write_reg(6, 8'hf0);
      write_reg(4, 8'hf7);
      write_reg(7, 8'h34);
      write_reg(8, 8'h12);
      write_reg(11, 8'h23);
      write_reg(18, 8'h41);
      write_reg(21, 8'hff);
      write_reg(22, 8'hff);
      write_reg(23, 8'hff);
      write_reg(24, 8'h70);
      write_reg(25, 8'hff);
      write_reg(31, 8'hff);
      send_item(tvss_pkg::CMD_SAMPLE, 5'h1f, 8'hff);
      send_item(tvss_pkg::CMD_SAMPLE, 5'h00, 8'h00);
      take_sample();
      // sync onto a silent source oscillator
      write_reg(0, 8'h00);
      write_reg(1, 8'h00);
      take_sample();
      write_reg(23, 8'h00);
      take_sample();
   endtask

   task automatic test_random_patches();
      int pick;
      while (items_sent < ITEM_GOAL) begin
         pick = $urandom_range(0, 99);
         if (pick < 12) begin
            repeat ($urandom_range(1, 6))
               send_item(tvss_pkg::cmd_type'($urandom_range(0, 1)), 5'($urandom),
                         8'($urandom));
         end else begin
            repeat ($urandom_range(1, 8)) begin
               if ($urandom_range(0, 3) == 0)
                  write_reg(7 * $urandom_range(0, 2) + 4, $urandom | 1);
               else
                  write_reg($urandom_range(0, tvss_pkg::NUM_REGS - 1), $urandom_range(0, 255));
            end
            repeat ($urandom_range(1, 50)) take_sample();
         end
      end
   endtask

   // receiver readiness changes character when a random countdown runs out
   int stall_mode;
   int stall_left;
   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(50, 400);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_tready <= 1'b1;
         1:       rsp_tready <= $urandom_range(0, 1);
         2:       rsp_tready <= ($urandom_range(0, 7) == 0);
         default: rsp_tready <= (cycles % 128) >= 100;
      endcase
   end

   always @(posedge clock) begin
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (expected_samples.size() == 0) begin
            $error("sample: unexpected transaction, actual %0d", $signed(rsp_tdata));
            errors++;
         end else begin
            if (rsp_tdata !== expected_samples[0]) begin
               $error("sample: expected %0d, actual %0d",
                      $signed(expected_samples[0]), $signed(rsp_tdata));
               errors++;
            end
            void'(expected_samples.pop_front());
            samples_checked++;
         end
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > MAX_CYCLE) begin
         $display("Timeout after %0d cycles", cycles);
         $display("Testbench completed WITH ERRORS");
         $finish;
      end
   end

   initial begin
      errors          = 0;
      cycles          = 0;
      items_sent      = 0;
      writes_sent     = 0;
      samples_checked = 0;
      burst_left      = 10;
      stall_mode      = 0;
      stall_left      = 0;
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tuser  <= tvss_pkg::CMD_WRITE;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      clear_synth_state();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_corner_cases();
      test_random_patches();
      req_tvalid <= 1'b0;

      while (expected_samples.size() != 0) @(posedge clock);
      repeat (300) @(posedge clock);

      $display("Covered %0d transactions: %0d register writes, %0d samples checked",
               items_sent, writes_sent, samples_checked);
      if (errors == 0 && expected_samples.size() == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule

`default_nettype wire

// File: filelist.f
hdl/tvss_pkg.sv
hdl/three_voice_sound_synth.sv
bench/three_voice_sound_synth_test.sv
